FILE: design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = 4;
  localparam int BLK_W      = 5;
  localparam int POL_W      = 2;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = CFG_IDX_W'(1);

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [POL_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic                 kind;
    logic [IDX_W-1:0]     block_index;
    logic [SIZE_BITS-1:0] amount;
  } in_word_t;

  typedef struct packed {
    logic                 granted;
    logic [IDX_W-1:0]     chosen_block;
    logic [SIZE_BITS-1:0] space_before;
    logic [SIZE_BITS-1:0] space_after;
    logic [CNT_W-1:0]     request_number;
  } out_word_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic                 live;
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] best;
  } token_t;

endpackage

FILE: design/pfa_cell.sv
// ----------------------------------------------------------------------------
// pfa_cell
// One partition: holds its free space and updates the passing scan token.
// ----------------------------------------------------------------------------
module pfa_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pfa_pkg::IDX_W-1:0]     cell_idx_i,
  input  logic                          en_i,
  input  logic [pfa_pkg::POL_W-1:0]     policy_i,
  input  logic [pfa_pkg::SIZE_BITS-1:0] amount_i,
  input  logic                          wr_en_i,
  input  logic [pfa_pkg::SIZE_BITS-1:0] wr_data_i,
  input  pfa_pkg::token_t               tok_i,
  output pfa_pkg::token_t               tok_o
);

  logic [pfa_pkg::SIZE_BITS-1:0] space_q;
  logic                          live_q;
  pfa_pkg::token_t               tok_d;
  pfa_pkg::token_t               tok_q;
  logic                          fits;
  logic                          better;
  logic                          take;

  always_comb begin
    fits   = en_i && (space_q >= amount_i);
    better = ((policy_i == pfa_pkg::FIT_BEST)  && (space_q < tok_i.best)) ||
             ((policy_i == pfa_pkg::FIT_WORST) && (space_q > tok_i.best));
    take   = fits && (!tok_i.found || better);
    tok_d  = tok_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.pick  = cell_idx_i;
      tok_d.best  = space_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      space_q <= wr_data_i;
    end
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= tok_i.live;
    end
  end

  always_comb begin
    tok_o      = tok_q;
    tok_o.live = live_q;
  end

endmodule

FILE: design/partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator
// First, best or worst fit allocation over a chain of partition cells.
// ----------------------------------------------------------------------------
// Load words write one partition's free space, so loads can follow back to
// back. A request word starts a scan token that walks the chain of NUM_BLOCKS
// cells, one cell per cycle; the chosen partition is updated when the token
// leaves the last cell. The result word is registered in the output register,
// and the next word can be accepted in the same cycle that the result appears.
// The input stalls during a scan and while a finished result waits behind a
// stalled output word; a result that sits in the output register does not
// block the next word.
module partition_fit_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pfa_pkg::in_word_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pfa_pkg::out_word_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  pfa_pkg::state_e               state_q, state_d;
  logic [pfa_pkg::POL_W-1:0]     policy_q;
  logic [pfa_pkg::BLK_W-1:0]     blocks_q;
  logic [pfa_pkg::CNT_W-1:0]     req_cnt_q;
  logic [pfa_pkg::SIZE_BITS-1:0] amount_q;
  logic                          start_q;
  logic                          out_valid_q;
  pfa_pkg::out_word_t            out_data_q;
  pfa_pkg::out_word_t            hold_q;
  pfa_pkg::out_word_t            res;
  pfa_pkg::token_t               tok [pfa_pkg::NUM_BLOCKS+1];
  pfa_pkg::token_t               last_tok;
  logic                          in_acc;
  logic                          load_acc;
  logic                          req_acc;
  logic                          out_free;
  logic                          res_to_out;
  logic                          res_to_hold;
  logic                          hold_to_out;
  logic [pfa_pkg::SIZE_BITS-1:0] wr_data;
  logic [pfa_pkg::SIZE_BITS-1:0] after;

  assign in_stall_o  = (state_q != pfa_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign load_acc = in_acc && (in_data_i.kind == pfa_pkg::KIND_LOAD) &&
                    ({1'b0, in_data_i.block_index} < (pfa_pkg::IDX_W+1)'(pfa_pkg::NUM_BLOCKS));
  assign req_acc  = in_acc && (in_data_i.kind == pfa_pkg::KIND_REQUEST);
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_tok = tok[pfa_pkg::NUM_BLOCKS];
  assign after    = last_tok.best - amount_q;
  assign wr_data  = load_acc ? in_data_i.amount : after;

  always_comb begin
    res.granted        = last_tok.found;
    res.chosen_block   = last_tok.found ? last_tok.pick : '0;
    res.space_before   = last_tok.found ? last_tok.best : '0;
    res.space_after    = last_tok.found ? after : '0;
    res.request_number = req_cnt_q;
  end

  always_comb begin
    tok[0]       = '0;
    tok[0].live  = start_q;
  end

  for (genvar i = 0; i < pfa_pkg::NUM_BLOCKS; i++) begin : g_cell
    logic wr_en;
    assign wr_en = (load_acc && (in_data_i.block_index == pfa_pkg::IDX_W'(i))) ||
                   (last_tok.live && last_tok.found && (last_tok.pick == pfa_pkg::IDX_W'(i)));
    pfa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (pfa_pkg::IDX_W'(i)),
      .en_i       ((pfa_pkg::BLK_W)'(i) < blocks_q),
      .policy_i   (policy_q),
      .amount_i   (amount_q),
      .wr_en_i    (wr_en),
      .wr_data_i  (wr_data),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    res_to_out  = 1'b0;
    res_to_hold = 1'b0;
    hold_to_out = 1'b0;
    case (state_q)
      pfa_pkg::ST_IDLE: begin
        if (req_acc) begin
          state_d = pfa_pkg::ST_SCAN;
        end
      end
      pfa_pkg::ST_SCAN: begin
        if (last_tok.live) begin
          if (out_free) begin
            res_to_out = 1'b1;
            state_d    = pfa_pkg::ST_IDLE;
          end else begin
            res_to_hold = 1'b1;
            state_d     = pfa_pkg::ST_HOLD;
          end
        end
      end
      pfa_pkg::ST_HOLD: begin
        if (out_free) begin
          hold_to_out = 1'b1;
          state_d     = pfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfa_pkg::ST_IDLE;
      policy_q    <= pfa_pkg::FIT_FIRST;
      blocks_q    <= pfa_pkg::BLK_W'(pfa_pkg::NUM_BLOCKS);
      req_cnt_q   <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= req_acc;
      if (req_acc) begin
        req_cnt_q <= req_cnt_q + 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pfa_pkg::CFG_FIT_POLICY:    policy_q <= cfg_data_i[pfa_pkg::POL_W-1:0];
          pfa_pkg::CFG_BLOCKS_IN_USE: blocks_q <= cfg_data_i[pfa_pkg::BLK_W-1:0];
          default: ;
        endcase
      end
      if (res_to_out || hold_to_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      amount_q <= in_data_i.amount;
    end
    if (res_to_hold) begin
      hold_q <= res;
    end
    if (res_to_out) begin
      out_data_q <= res;
    end else if (hold_to_out) begin
      out_data_q <= hold_q;
    end
  end

`ifndef SYNTHESIS
  a_tok_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_tok.live |-> state_q == pfa_pkg::ST_SCAN)
    else $error("scan token left chain outside scan");

  a_hold_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pfa_pkg::ST_HOLD |-> out_valid_q)
    else $error("result held while output register empty");

  a_grant_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.granted |-> out_data_q.space_before >= out_data_q.space_after)
    else $error("granted space grew");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.granted |-> out_data_q.chosen_block == '0 &&
      out_data_q.space_before == '0 && out_data_q.space_after == '0)
    else $error("refused word carries data");
`endif

endmodule
